/* rtl/lfre_pkg.sv */
// ----------------------------------------------------------------------------
// lfre_pkg: loop flag register engine package
// Field widths, operation codes, register indexes and controller states.
// ----------------------------------------------------------------------------
package lfre_pkg;

  localparam int unsigned IndexW   = 4;
  localparam int unsigned UpdOpW   = 3;
  localparam int unsigned OperandW = 14;
  localparam int unsigned CmpOpW   = 3;
  localparam int unsigned ValueW   = 14;

  // input tdata: flag_index, update_op, indirect, operand, compare_op, ref_value
  localparam int unsigned InDataW  = 40;
  // output tdata: jump_taken, flag_value
  localparam int unsigned OutDataW = 16;

  localparam int unsigned CfgIndexW = 1;

  localparam logic [CfgIndexW-1:0] CFG_FLAGS_ENABLED    = 1'd0;
  localparam logic [CfgIndexW-1:0] CFG_LOOPING_DISABLED = 1'd1;

  typedef enum logic {
    ACT_UPDATE = 1'b0,
    ACT_CHECK  = 1'b1
  } action_e;

  typedef enum logic [UpdOpW-1:0] {
    UPD_SET = 3'd0,
    UPD_ADD = 3'd1,
    UPD_SUB = 3'd2,
    UPD_INC = 3'd3,
    UPD_DEC = 3'd4
  } upd_op_e;

  typedef enum logic [CmpOpW-1:0] {
    CMP_NONE = 3'd0,
    CMP_EQ   = 3'd1,
    CMP_NE   = 3'd2,
    CMP_GT   = 3'd3,
    CMP_GE   = 3'd4,
    CMP_LT   = 3'd5,
    CMP_LE   = 3'd6
  } cmp_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

/* rtl/loop_flag_register_engine_top.sv */
// ----------------------------------------------------------------------------
// loop_flag_register_engine_top
// Flag file with saturating updates and loop condition checks.
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser action, tdata item fields
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata jump_taken, flag_value
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// in each transaction the accept edge issues the flag memory
// reads (target and indirect operand), the next cycle computes and writes back.
// the next item is accepted only after write back, back in idle, so reads never see stale data.
// reset clears the per-entry valid bits at once; no clearing pass is run.
// a result waits in the output register; a stalled output holds the input off
// only when a new result would have nowhere to go.
// ----------------------------------------------------------------------------
module loop_flag_register_engine_top
  import lfre_pkg::*;
#(
  parameter int unsigned FLAG_COUNT = 16,
  parameter int unsigned FLAG_MAX   = 9999
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [3:0] flag_index, [6:4] update_op, [7] indirect, [21:8] operand,
  // [24:22] compare_op, [38:25] ref_value, [39] zero
  input  logic [InDataW-1:0]   s_axis_tdata,
  // [0] action
  input  logic                 s_axis_tuser,

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] jump_taken, [14:1] flag_value, [15] zero
  output logic [OutDataW-1:0]  m_axis_tdata,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic                 cfg_data_i
);

  localparam int unsigned IDX_W = (FLAG_COUNT > 1) ? $clog2(FLAG_COUNT) : 1;
  localparam int unsigned VAL_W = $clog2(FLAG_MAX + 1);

  function automatic logic [IDX_W-1:0] clip_idx(input logic [OperandW-1:0] v);
    if (32'(v) >= FLAG_COUNT) begin
      return IDX_W'(FLAG_COUNT - 1);
    end
    return IDX_W'(v);
  endfunction

  function automatic logic [VAL_W-1:0] clip_val(input logic [OperandW-1:0] v);
    if (32'(v) >= FLAG_MAX) begin
      return VAL_W'(FLAG_MAX);
    end
    return VAL_W'(v);
  endfunction

  // configuration
  logic flags_en_q, loop_dis_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_en_q <= 1'b0;
      loop_dis_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FLAGS_ENABLED:    flags_en_q <= cfg_data_i;
        CFG_LOOPING_DISABLED: loop_dis_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // controller
  state_e state_q, state_d;
  logic   in_acc;
  logic   out_valid_q;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = !out_valid_q || m_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item capture
  action_e          act_q;
  upd_op_e          upd_q;
  cmp_op_e          cmp_q;
  logic             indir_q;
  logic [IDX_W-1:0] tgt_q;
  logic [VAL_W-1:0] imm_q, ref_q;
  logic [IDX_W-1:0] rd_a, rd_b;

  assign rd_a = clip_idx(OperandW'(s_axis_tdata[3:0]));
  assign rd_b = clip_idx(s_axis_tdata[21:8]);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q   <= action_e'(s_axis_tuser);
      tgt_q   <= rd_a;
      upd_q   <= upd_op_e'(s_axis_tdata[6:4]);
      indir_q <= s_axis_tdata[7];
      imm_q   <= clip_val(s_axis_tdata[21:8]);
      cmp_q   <= cmp_op_e'(s_axis_tdata[24:22]);
      ref_q   <= clip_val(s_axis_tdata[38:25]);
    end
  end

  // flag memory, two registered read ports and one write port
  logic [VAL_W-1:0]      flag_mem [FLAG_COUNT];
  logic [FLAG_COUNT-1:0] vld_q;
  logic [VAL_W-1:0]      rd_a_q, rd_b_q;
  logic                  rd_a_vld_q, rd_b_vld_q;
  logic                  mem_we;
  logic [VAL_W-1:0]      wr_data;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      flag_mem[tgt_q] <= wr_data;
    end
    if (in_acc) begin
      rd_a_q <= flag_mem[rd_a];
      rd_b_q <= flag_mem[rd_b];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_a_vld_q <= 1'b0;
      rd_b_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[tgt_q] <= 1'b1;
      end
      if (in_acc) begin
        rd_a_vld_q <= vld_q[rd_a];
        rd_b_vld_q <= vld_q[rd_b];
      end
    end
  end

  // modify
  logic [VAL_W-1:0] cur, arg, new_val;
  logic [VAL_W:0]   sum;
  logic             cond, jump;

  always_comb begin
    cur     = rd_a_vld_q ? rd_a_q : '0;
    arg     = indir_q ? (rd_b_vld_q ? rd_b_q : '0) : imm_q;
    sum     = {1'b0, cur} + {1'b0, arg};
    new_val = cur;
    case (upd_q)
      UPD_SET: new_val = arg;
      UPD_ADD: new_val = (sum > (VAL_W + 1)'(FLAG_MAX)) ? VAL_W'(FLAG_MAX) : sum[VAL_W-1:0];
      UPD_SUB: new_val = (cur >= arg) ? cur - arg : '0;
      UPD_INC: new_val = (cur >= VAL_W'(FLAG_MAX)) ? VAL_W'(FLAG_MAX) : cur + 1'b1;
      UPD_DEC: new_val = (cur != '0) ? cur - 1'b1 : '0;
      default: new_val = cur;
    endcase

    case (cmp_q)
      CMP_EQ:  cond = cur == ref_q;
      CMP_NE:  cond = cur != ref_q;
      CMP_GT:  cond = cur >  ref_q;
      CMP_GE:  cond = cur >= ref_q;
      CMP_LT:  cond = cur <  ref_q;
      CMP_LE:  cond = cur <= ref_q;
      default: cond = 1'b1;
    endcase

    mem_we  = (state_q == S_EXEC) && (act_q == ACT_UPDATE) && flags_en_q && !loop_dis_q;
    wr_data = new_val;
    jump    = (act_q == ACT_CHECK) && !loop_dis_q && (!flags_en_q || cond);
  end

  // output register
  logic [OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EXEC) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      out_data_q <= {1'b0, ValueW'(mem_we ? new_val : cur), jump};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
  a_acc_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_EXEC)
    else $error("accepted item did not enter execute");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> m_axis_tvalid)
    else $error("execute cycle produced no result");

  a_we_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == S_EXEC && !loop_dis_q)
    else $error("flag write outside execute");

  a_wr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> 32'(wr_data) <= FLAG_MAX)
    else $error("flag write above maximum");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> !out_valid_q || $past(m_axis_tready))
    else $error("result overwrote a pending one");
`endif

endmodule
